FILE: rtl/core/eq5_pkg.sv
package eq5_pkg;

    localparam int TAPS_DEF = 64;
    localparam int NBANDS   = 5;
    localparam int SMP_W    = 16;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int BAND_W   = 3;
    localparam int TAPIDX_W = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd5;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    // output scaling: total / (5 * 2^27), trunc toward zero, saturate
    localparam int DIV_SHIFT   = 27;
    localparam int RECIP_5     = 52429;   // ceil(2^18 / 5)
    localparam int RECIP_SHIFT = 18;
    localparam int POS_LIM     = 163840;  // 5 * 32768
    localparam int NEG_LIM     = 163845;  // 5 * 32769
    localparam int QDEPTH      = 2;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_COEF   = 1'b1
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic                      channel;
        logic signed [SMP_W-1:0]   sample;
        logic [BAND_W-1:0]         band;
        logic [TAPIDX_W-1:0]       tap;
        logic signed [COEF_W-1:0]  coef;
    } t_item;

    typedef struct packed {
        logic [NBANDS-1:0][GAIN_W-1:0] gain;
        logic                          enable;
    } t_cfg;

endpackage

FILE: rtl/core/eq5_if.sv
interface eq5_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic                                channel;
    logic signed [eq5_pkg::SMP_W-1:0]    sample_in;
    logic [eq5_pkg::BAND_W-1:0]          band_sel;
    logic [eq5_pkg::TAPIDX_W-1:0]        tap_index;
    logic signed [eq5_pkg::COEF_W-1:0]   coef_value;
    modport source (output valid, kind, channel, sample_in, band_sel, tap_index, coef_value,
                    input ready);
    modport sink   (input valid, kind, channel, sample_in, band_sel, tap_index, coef_value,
                    output ready);
endinterface

interface eq5_out_if;
    logic                             valid;
    logic                             ready;
    logic                             out_channel;
    logic signed [eq5_pkg::SMP_W-1:0] sample_out;
    modport source (output valid, out_channel, sample_out, input ready);
    modport sink   (input valid, out_channel, sample_out, output ready);
endinterface

interface eq5_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [eq5_pkg::CFG_IDX_W-1:0]        index;
    logic [eq5_pkg::CFG_DAT_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/eq5_ram.sv
module eq5_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/core/eq5_front.sv
module eq5_front #(
    parameter int TAPS = eq5_pkg::TAPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    eq5_in_if.sink         i_in_ch,
    eq5_cfg_if.sink        i_cfg,
    input  logic           i_hold,
    input  logic           i_pop,
    output logic           o_item_valid,
    output eq5_pkg::t_item o_item,
    output eq5_pkg::t_cfg  o_cfg
);
    eq5_pkg::t_item r_q [eq5_pkg::QDEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           in_acc;
    logic           keep;
    logic           push;
    eq5_pkg::t_item new_item;
    eq5_pkg::t_cfg  r_cfg;

    assign i_in_ch.ready = (r_cnt != 2'(eq5_pkg::QDEPTH)) && !i_hold;
    assign in_acc        = i_in_ch.valid && i_in_ch.ready;

    // coefficient writes to a bad band or tap are dropped here
    assign keep = (i_in_ch.kind == 1'b0) ||
                  ((32'(i_in_ch.band_sel) < 32'(eq5_pkg::NBANDS)) &&
                   (32'(i_in_ch.tap_index) < 32'(TAPS)));
    assign push = in_acc && keep;

    always_comb begin
        new_item.op      = i_in_ch.kind ? eq5_pkg::OP_COEF : eq5_pkg::OP_SAMPLE;
        new_item.channel = i_in_ch.channel;
        new_item.sample  = i_in_ch.sample_in;
        new_item.band    = i_in_ch.band_sel;
        new_item.tap     = i_in_ch.tap_index;
        new_item.coef    = i_in_ch.coef_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < eq5_pkg::NBANDS; b++) begin
                r_cfg.gain[b] <= eq5_pkg::GAIN_RESET;
            end
            r_cfg.enable <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                eq5_pkg::REG_GAIN0:  r_cfg.gain[0] <= i_cfg.data;
                eq5_pkg::REG_GAIN1:  r_cfg.gain[1] <= i_cfg.data;
                eq5_pkg::REG_GAIN2:  r_cfg.gain[2] <= i_cfg.data;
                eq5_pkg::REG_GAIN3:  r_cfg.gain[3] <= i_cfg.data;
                eq5_pkg::REG_GAIN4:  r_cfg.gain[4] <= i_cfg.data;
                eq5_pkg::REG_ENABLE: r_cfg.enable  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

FILE: rtl/core/eq5_back.sv
module eq5_back #(
    parameter int TAPS = eq5_pkg::TAPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  eq5_pkg::t_item i_item,
    input  eq5_pkg::t_cfg  i_cfg,
    output logic           o_pop,
    output logic           o_clearing,
    eq5_out_if.source      o_out_ch
);
    localparam int TW   = $clog2(TAPS);
    localparam int HAW  = $clog2(2 * TAPS);
    localparam int CAW  = $clog2(eq5_pkg::NBANDS * TAPS);
    localparam int PW   = 2 * eq5_pkg::SMP_W;
    localparam int AW   = PW + TW;
    localparam int SW   = AW + eq5_pkg::GAIN_W;
    localparam int TOTW = SW + 3;
    localparam int YW   = TOTW - eq5_pkg::DIV_SHIFT;
    localparam int QW   = eq5_pkg::RECIP_SHIFT + 17;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MAC, S_WAIT, S_ABS, S_MUL, S_FIN
    } t_state;

    t_state                         r_state;
    logic [HAW-1:0]                 r_clr;
    logic [TW-1:0]                  r_ptr [2];
    logic                           r_ch;
    logic [TW-1:0]                  r_hidx;
    logic [TW-1:0]                  r_tap;
    logic [2:0]                     r_band;
    logic [CAW-1:0]                 r_caddr;
    logic                           r_out_v;
    logic                           r_out_ch;
    logic signed [eq5_pkg::SMP_W-1:0] r_out_smp;
    logic                           r_neg;
    logic [TOTW-1:0]                r_mag;
    logic                           r_sat_hi;
    logic                           r_sat_lo;
    logic [QW-1:0]                  r_qprod;

    // datapath pipeline
    logic                           r_v1, r_f1, r_l1;
    logic                           r_v2, r_f2, r_l2;
    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_acc;
    logic                           r_av;
    logic [2:0]                     r_accb;
    logic signed [SW-1:0]           r_scaled;
    logic                           r_sv;
    logic [2:0]                     r_nadd;
    logic signed [TOTW-1:0]         r_total;

    logic                           out_free;
    logic                           out_load;
    logic                           start;
    logic [TW-1:0]                  nptr;
    logic                           h_we;
    logic [HAW-1:0]                 h_waddr;
    logic [eq5_pkg::SMP_W-1:0]      h_wdata;
    logic [HAW-1:0]                 h_raddr;
    logic [eq5_pkg::SMP_W-1:0]      h_rdata;
    logic                           c_we;
    logic [CAW-1:0]                 c_waddr;
    logic [eq5_pkg::COEF_W-1:0]     c_rdata;
    logic [YW-1:0]                  ym;
    logic [16:0]                    qx;
    logic [16:0]                    qs;
    logic signed [eq5_pkg::SMP_W-1:0] res;

    function automatic logic [HAW-1:0] hist_addr(input logic ch, input logic [TW-1:0] idx);
        hist_addr = ch ? (HAW'(TAPS) + HAW'(idx)) : HAW'(idx);
    endfunction

    assign out_free = !r_out_v || o_out_ch.ready;

    always_comb begin
        o_pop = 1'b0;
        if (r_state == S_IDLE && i_item_valid) begin
            o_pop = (i_item.op == eq5_pkg::OP_COEF) || i_cfg.enable || out_free;
        end
    end

    assign start = o_pop && (i_item.op == eq5_pkg::OP_SAMPLE) && i_cfg.enable;
    assign nptr  = (r_ptr[i_item.channel] == '0) ? TW'(TAPS - 1)
                                                 : r_ptr[i_item.channel] - 1'b1;

    // output register loads a bypassed sample or a finished result
    assign out_load = (r_state == S_FIN && out_free) ||
                      (r_state == S_IDLE && o_pop && i_item.op == eq5_pkg::OP_SAMPLE &&
                       !start);

    assign h_we    = (r_state == S_CLEAR) || start;
    assign h_waddr = (r_state == S_CLEAR) ? r_clr : hist_addr(i_item.channel, nptr);
    assign h_wdata = (r_state == S_CLEAR) ? '0 : i_item.sample;
    assign h_raddr = hist_addr(r_ch, r_hidx);

    assign c_we    = o_pop && (i_item.op == eq5_pkg::OP_COEF);
    assign c_waddr = CAW'(int'(i_item.band) * TAPS + int'(i_item.tap));

    eq5_ram #(.WIDTH(eq5_pkg::SMP_W), .DEPTH(2 * TAPS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    eq5_ram #(.WIDTH(eq5_pkg::COEF_W), .DEPTH(eq5_pkg::NBANDS * TAPS)) u_coef (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_item.coef),
        .i_raddr (r_caddr),
        .o_rdata (c_rdata)
    );

    // scaling helpers
    assign ym  = YW'(r_mag >> eq5_pkg::DIV_SHIFT);
    assign qx  = {1'b0, r_qprod[eq5_pkg::RECIP_SHIFT +: 16]};
    assign qs  = r_neg ? (17'd0 - qx) : qx;
    assign res = r_sat_hi ? 16'sh7FFF : (r_sat_lo ? 16'sh8000 : qs[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ptr[0] <= '0;
            r_ptr[1] <= '0;
            r_out_v <= 1'b0;
            r_ch    <= 1'b0;
            r_hidx  <= '0;
            r_tap   <= '0;
            r_band  <= '0;
            r_caddr <= '0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HAW'(2 * TAPS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_ptr[i_item.channel] <= nptr;
                        r_ch    <= i_item.channel;
                        r_hidx  <= nptr;
                        r_tap   <= '0;
                        r_band  <= '0;
                        r_caddr <= '0;
                        r_state <= S_MAC;
                    end else if (o_pop && i_item.op == eq5_pkg::OP_SAMPLE) begin
                        r_out_ch  <= i_item.channel;
                        r_out_smp <= i_item.sample;
                    end
                end
                S_MAC: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_tap == TW'(TAPS - 1)) begin
                        r_tap  <= '0;
                        r_hidx <= r_ptr[r_ch];
                        r_band <= r_band + 1'b1;
                        if (r_band == 3'(eq5_pkg::NBANDS - 1)) begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_tap  <= r_tap + 1'b1;
                        r_hidx <= (r_hidx == TW'(TAPS - 1)) ? '0 : r_hidx + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (r_nadd == 3'(eq5_pkg::NBANDS)) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_total[TOTW-1];
                    r_mag   <= r_total[TOTW-1] ? TOTW'(-r_total) : TOTW'(r_total);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sat_hi <= !r_neg && (ym >= YW'(eq5_pkg::POS_LIM));
                    r_sat_lo <= r_neg && (ym >= YW'(eq5_pkg::NEG_LIM));
                    r_qprod  <= QW'(ym[17:0]) * QW'(eq5_pkg::RECIP_5);
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_ch  <= r_ch;
                        r_out_smp <= res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // MAC pipeline: read, multiply, accumulate, gain, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_av   <= 1'b0;
            r_sv   <= 1'b0;
            r_accb <= '0;
            r_nadd <= '0;
        end else begin
            r_v1 <= (r_state == S_MAC);
            r_v2 <= r_v1;
            r_av <= r_v2 && r_l2;
            r_sv <= r_av;
            if (start) begin
                r_accb <= '0;
                r_nadd <= '0;
            end else begin
                if (r_av) begin
                    r_accb <= r_accb + 1'b1;
                end
                if (r_sv) begin
                    r_nadd <= r_nadd + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1   <= (r_tap == '0);
        r_l1   <= (r_tap == TW'(TAPS - 1));
        r_f2   <= r_f1;
        r_l2   <= r_l1;
        r_prod <= $signed(c_rdata) * $signed(h_rdata);
        if (r_v2) begin
            r_acc <= r_f2 ? AW'(r_prod) : r_acc + AW'(r_prod);
        end
        if (r_av) begin
            r_scaled <= r_acc * $signed(i_cfg.gain[r_accb]);
        end
        if (r_sv) begin
            r_total <= (r_nadd == '0) ? TOTW'(r_scaled) : r_total + TOTW'(r_scaled);
        end
    end

    assign o_clearing          = (r_state == S_CLEAR);
    assign o_out_ch.valid       = r_out_v;
    assign o_out_ch.out_channel = r_out_ch;
    assign o_out_ch.sample_out  = r_out_smp;
endmodule

FILE: rtl/core/five_band_fir_equalizer.sv
// Five-band stereo FIR graphic equalizer.
// Channels (valid/ready, a beat moves at a clock edge with both high):
//   i_in_ch : input beats. kind 0 = audio sample for channel 0/1,
//             kind 1 = coefficient write (band_sel, tap_index, coef_value).
//   o_out_ch: one beat per audio sample, none per coefficient write.
//   i_cfg   : register writes, index 0..4 band gains (Q4.12), 5 enable_eq.
//             Always ready; write only while the block is idle.
// Processing:
//   coefficient write: stored in coefficient memory when popped, no output.
//   bypass sample (enable_eq = 0): goes from the queue to the output register.
//   filtered sample: processed one at a time, the pace set by
//   the single shared MAC walking every tap of all five bands in turn.
// Reset: synchronous, active low. After release the history memory is
// zeroed entry by entry; input ready stays low during that sweep.
// Coefficient memory is not cleared; load all taps before filtering.
// Stall: a 2-deep queue sits between the front and the MAC engine, and the
// result sits in an output register, so input is still taken while the
// receiver stalls until the queue fills.
module five_band_fir_equalizer #(
    parameter int TAPS = eq5_pkg::TAPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eq5_in_if.sink    i_in_ch,
    eq5_cfg_if.sink   i_cfg,
    eq5_out_if.source o_out_ch
);
    logic           item_valid;
    logic           pop;
    logic           clearing;
    eq5_pkg::t_item item;
    eq5_pkg::t_cfg  cfg;

    // front: accept, classify, queue; holds the register file
    eq5_front #(.TAPS(TAPS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (i_in_ch),
        .i_cfg        (i_cfg),
        .i_hold       (clearing),
        .i_pop        (pop),
        .o_item_valid (item_valid),
        .o_item       (item),
        .o_cfg        (cfg)
    );

    // back: memories, MAC pipeline, scaling and output register
    eq5_back #(.TAPS(TAPS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_cfg        (cfg),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_ch     (o_out_ch)
    );
endmodule

FILE: rtl/core/eq5_checker.sv
module eq5_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_channel,
    input logic [15:0] sample_out
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(sample_out) && $stable(out_channel))
        else $error("result changed while stalled");

    // reset empties the output and starts the history sweep
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !in_ready)
        else $error("input taken during history sweep");
endmodule

bind five_band_fir_equalizer eq5_props u_eq5_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (i_in_ch.ready),
    .out_valid   (o_out_ch.valid),
    .out_ready   (o_out_ch.ready),
    .out_channel (o_out_ch.out_channel),
    .sample_out  (o_out_ch.sample_out)
);

FILE: verif/eq5_checker.sv
`timescale 1ns / 1ps

module eq5_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    eq5_in_if    in_ch,
    eq5_cfg_if   cfg_ch,
    eq5_out_if   out_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_results
);
    typedef struct packed {
        logic                             ch;
        logic signed [eq5_pkg::SMP_W-1:0] smp;
    } t_eq_beat;

    t_eq_beat                          want_q[$];
    logic signed [eq5_pkg::SMP_W-1:0]  hist[2][eq5_pkg::TAPS_DEF];
    logic signed [eq5_pkg::COEF_W-1:0] coefs[eq5_pkg::NBANDS][eq5_pkg::TAPS_DEF];
    logic signed [eq5_pkg::GAIN_W-1:0] gains[eq5_pkg::NBANDS];
    logic                              eq_on;

    // history shifts only when filtering; bypass leaves it alone
    function automatic t_eq_beat equalize(logic ch, logic signed [eq5_pkg::SMP_W-1:0] smp);
        longint   total;
        longint   acc;
        longint   q;
        t_eq_beat r;
        r.ch = ch;
        r.smp = smp;
        if (!eq_on) return r;
        for (int k = eq5_pkg::TAPS_DEF - 1; k > 0; k--) hist[ch][k] = hist[ch][k-1];
        hist[ch][0] = smp;
        total = 0;
        for (int b = 0; b < eq5_pkg::NBANDS; b++) begin
            acc = 0;
            for (int k = 0; k < eq5_pkg::TAPS_DEF; k++)
                acc += longint'(coefs[b][k]) * longint'(hist[ch][k]);
            total += acc * longint'(gains[b]);
        end
        q = total / (longint'(eq5_pkg::NBANDS) * (longint'(1) << eq5_pkg::DIV_SHIFT));
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        r.smp = q[eq5_pkg::SMP_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_eq_beat got;
        t_eq_beat exp_b;
        if (!i_rst_n) begin
            want_q.delete();
            for (int c = 0; c < 2; c++)
                for (int k = 0; k < eq5_pkg::TAPS_DEF; k++) hist[c][k] = '0;
            for (int b = 0; b < eq5_pkg::NBANDS; b++) begin
                gains[b] = eq5_pkg::GAIN_RESET;
                for (int k = 0; k < eq5_pkg::TAPS_DEF; k++) coefs[b][k] = '0;
            end
            eq_on = 1'b1;
            o_errors = 0;
            o_results = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index < eq5_pkg::NBANDS) gains[cfg_ch.index] = cfg_ch.data;
                else if (cfg_ch.index == eq5_pkg::REG_ENABLE) eq_on = cfg_ch.data[0];
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.kind == eq5_pkg::OP_COEF) begin
                    if (in_ch.band_sel < eq5_pkg::NBANDS)
                        coefs[in_ch.band_sel][in_ch.tap_index] = in_ch.coef_value;
                end else begin
                    want_q.push_back(equalize(in_ch.channel, in_ch.sample_in));
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got.ch = out_ch.out_channel;
                got.smp = out_ch.sample_out;
                o_results++;
                if (want_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("ERROR: unexpected beat ch=%0d smp=%0d", got.ch, got.smp);
                end else begin
                    exp_b = want_q.pop_front();
                    if (got.ch !== exp_b.ch || got.smp !== exp_b.smp) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("ERROR: exp ch=%0d smp=%0d got ch=%0d smp=%0d",
                                     exp_b.ch, exp_b.smp, got.ch, got.smp);
                    end
                end
            end
        end
        o_pending = want_q.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n;
    int   n_errors, n_pending, n_results;
    int   n_samples, n_coefs, n_cfg;
    int   burst_left;
    logic hold_off;     // long receiver stall to back up the queue

    eq5_in_if  in_ch();
    eq5_cfg_if cfg_ch();
    eq5_out_if out_ch();

    five_band_fir_equalizer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .i_cfg    (cfg_ch),
        .o_out_ch (out_ch)
    );

    eq5_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .cfg_ch    (cfg_ch),
        .out_ch    (out_ch),
        .o_errors  (n_errors),
        .o_pending (n_pending),
        .o_results (n_results)
    );

    always #10 i_clk = ~i_clk;

    // hard stop, far beyond the slowest legal run
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: switches between always-ready, light and heavy stalling
    initial begin
        int mode;
        int left;
        out_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 400);
            end
            left--;
            if (hold_off) out_ch.ready <= 1'b0;
            else if (mode == 0) out_ch.ready <= 1'b1;
            else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
            else out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // one long hold-off mid run; sender keeps pushing so input backs up
    initial begin
        hold_off = 1'b0;
        wait (n_samples >= 60);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // drive one beat, hold until taken; gaps only between bursts
    task automatic send_beat(logic kind, logic ch, logic signed [15:0] smp,
                             logic [2:0] band, logic [5:0] tap, logic signed [15:0] coef);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.channel    <= ch;
        in_ch.sample_in  <= smp;
        in_ch.band_sel   <= band;
        in_ch.tap_index  <= tap;
        in_ch.coef_value <= coef;
        do @(posedge i_clk); while (!in_ch.ready);
        if (kind == eq5_pkg::OP_COEF) n_coefs++;
        else n_samples++;
    endtask

    task automatic send_sample(logic ch, logic signed [15:0] smp);
        send_beat(eq5_pkg::OP_SAMPLE, ch, smp, 3'($urandom), 6'($urandom), 16'($urandom));
    endtask

    task automatic send_coef(logic [2:0] band, logic [5:0] tap, logic signed [15:0] coef);
        send_beat(eq5_pkg::OP_COEF, 1'($urandom), 16'($urandom), band, tap, coef);
    endtask

    // a coefficient write causes no beat, so leave room past the last one
    task automatic drain_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        n_cfg++;
    endtask

    task automatic set_gains(logic [15:0] g0, logic [15:0] g1, logic [15:0] g2,
                             logic [15:0] g3, logic [15:0] g4, logic en);
        cfg_write(eq5_pkg::REG_GAIN0, g0);
        cfg_write(eq5_pkg::REG_GAIN1, g1);
        cfg_write(eq5_pkg::REG_GAIN2, g2);
        cfg_write(eq5_pkg::REG_GAIN3, g3);
        cfg_write(eq5_pkg::REG_GAIN4, g4);
        cfg_write(eq5_pkg::REG_ENABLE, {15'd0, en});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_smp();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // random phase: mostly samples, some coefficient rewrites, a few to bad bands
    task automatic rand_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_coef(3'($urandom_range(0, 7)), 6'($urandom), pick_coef());
            else
                send_sample(1'($urandom), pick_smp());
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= eq5_pkg::OP_SAMPLE;
        in_ch.channel    <= 1'b0;
        in_ch.sample_in  <= '0;
        in_ch.band_sel   <= '0;
        in_ch.tap_index  <= '0;
        in_ch.coef_value <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= eq5_pkg::REG_GAIN0;
        cfg_ch.data      <= '0;
        n_samples = 0;
        n_coefs = 0;
        n_cfg = 0;
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients are undefined until written: load every tap first
        for (int b = 0; b < eq5_pkg::NBANDS; b++)
            for (int k = 0; k < eq5_pkg::TAPS_DEF; k++)
                send_coef(3'(b), 6'(k), pick_coef());

        // directed: field extremes, both channels, bad bands, bypass
        send_sample(1'b0, 16'sh7FFF);
        send_sample(1'b1, 16'sh8000);
        send_sample(1'b0, 16'sh0000);
        send_sample(1'b1, -16'sd1);
        send_sample(1'b0, 16'sd1);
        send_coef(3'd5, 6'd0, 16'sh7FFF);
        send_coef(3'd7, 6'd63, 16'sh8000);
        send_coef(3'd4, 6'd63, 16'sh8000);
        send_coef(3'd0, 6'd0, 16'sh7FFF);
        send_sample(1'b0, 16'sh8000);
        send_sample(1'b1, 16'sh7FFF);
        drain_idle();
        set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(1'($urandom), i[0] ? 16'sh7FFF : 16'sh8000);
        drain_idle();
        set_gains(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 1'b0);
        send_sample(1'b0, 16'sh7FFF);
        send_sample(1'b1, 16'sh8000);
        send_sample(1'b0, 16'sh1234);
        drain_idle();

        // random phases over several gain settings, extremes included
        set_gains(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 1'b1);
        rand_phase(80);
        drain_idle();
        set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        rand_phase(30);
        drain_idle();
        set_gains(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001, 1'b0);
        rand_phase(30);
        drain_idle();
        set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'b1);
        rand_phase(40);
        drain_idle();
        set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        rand_phase(30);
        drain_idle();

        $display("Covered %0d samples, %0d coefficient writes, %0d register writes,",
                 n_samples, n_coefs, n_cfg);
        $display("%0d output beats checked, bypass and saturating gains included.", n_results);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
